// ===== design/fatcm_pkg.sv =====
// shared types, codes and the control store of the fat cluster chain manager
package fatcm_pkg;

  // widths fixed by the item fields
  localparam int FUNC_W   = 3;
  localparam int CLU_W    = 10;
  localparam int CNT_W    = 10;
  localparam int ENT_W    = 12;
  localparam int STAT_W   = 2;
  localparam int EIU_W    = 11;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam logic [EIU_W-1:0] EIU_RESET = 11'd1024;

  // table entry codes
  localparam logic [ENT_W-1:0] ENT_FREE    = 12'd0;
  localparam logic [ENT_W-1:0] ENT_INVALID = 12'd1;
  localparam logic [ENT_W-1:0] ENT_END     = 12'd4095;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_EXTEND = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BROKEN = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CLU_W-1:0]  cluster;
    logic [CNT_W-1:0]  count;
    logic [ENT_W-1:0]  entry_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CLU_W-1:0]  cluster_out;
    logic [CNT_W-1:0]  count_out;
    logic [ENT_W-1:0]  entry_out;
  } out_item_t;

  // microprogram step addresses
  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] UPC_CLR      = 5'd0;
  localparam logic [UPC_W-1:0] UPC_IDLE     = 5'd1;
  localparam logic [UPC_W-1:0] UPC_DISPATCH = 5'd2;
  localparam logic [UPC_W-1:0] UPC_RD0      = 5'd3;
  localparam logic [UPC_W-1:0] UPC_RD1      = 5'd4;
  localparam logic [UPC_W-1:0] UPC_WR0      = 5'd5;
  localparam logic [UPC_W-1:0] UPC_WR1      = 5'd6;
  localparam logic [UPC_W-1:0] UPC_AL0      = 5'd7;
  localparam logic [UPC_W-1:0] UPC_AL1      = 5'd8;
  localparam logic [UPC_W-1:0] UPC_AL_OK    = 5'd9;
  localparam logic [UPC_W-1:0] UPC_FULL     = 5'd10;
  localparam logic [UPC_W-1:0] UPC_EX0      = 5'd11;
  localparam logic [UPC_W-1:0] UPC_WK0      = 5'd12;
  localparam logic [UPC_W-1:0] UPC_WK1      = 5'd13;
  localparam logic [UPC_W-1:0] UPC_WK2      = 5'd14;
  localparam logic [UPC_W-1:0] UPC_WK3      = 5'd15;
  localparam logic [UPC_W-1:0] UPC_ES0      = 5'd16;
  localparam logic [UPC_W-1:0] UPC_ES1      = 5'd17;
  localparam logic [UPC_W-1:0] UPC_ES2      = 5'd18;
  localparam logic [UPC_W-1:0] UPC_ES3      = 5'd19;
  localparam logic [UPC_W-1:0] UPC_ES_JMP   = 5'd20;
  localparam logic [UPC_W-1:0] UPC_BAD      = 5'd21;
  localparam logic [UPC_W-1:0] UPC_FR0      = 5'd22;
  localparam logic [UPC_W-1:0] UPC_FR1      = 5'd23;
  localparam logic [UPC_W-1:0] UPC_DONE     = 5'd24;
  localparam logic [UPC_W-1:0] UPC_PUSH     = 5'd25;

  typedef enum logic [1:0] {
    ADDR_CUR,
    ADDR_SCAN,
    ADDR_TAIL
  } addr_sel_e;

  typedef enum logic [1:0] {
    DAT_VALUE,
    DAT_END,
    DAT_FREE,
    DAT_SCAN
  } data_sel_e;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_ACCEPT,
    C_DISPATCH,
    C_CLR_LAST,
    C_OUT_RANGE,
    C_SCAN_END,
    C_FREE_HIT,
    C_WALK_BAD,
    C_RD_BAD,
    C_RD_END,
    C_CNT_ZERO,
    C_IS_FREE,
    C_CNT_LAST,
    C_FREE_STOP,
    C_OUT_BUSY
  } cond_e;

  // one control word per step
  typedef struct packed {
    logic       rd_en;
    addr_sel_e  rd_addr;
    logic       wr_en;
    addr_sel_e  wr_addr;
    data_sel_e  wr_data;
    logic       ld_cmd;
    logic       scan_inc;
    logic       scan_miss_inc;
    logic       visit_inc;
    logic       cur_from_rdata;
    logic       cur_from_cmd;
    logic       tail_from_cur;
    logic       tail_from_scan;
    logic       cnt_inc;
    logic       set_eout;
    logic       set_cout;
    logic       st_full;
    logic       st_broken;
    logic       push;
    cond_e      cond;
    logic       cond_neg;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic clr_last;
    logic out_range;
    logic scan_end;
    logic free_hit;
    logic walk_bad;
    logic rd_bad;
    logic rd_end;
    logic cnt_zero;
    logic is_free;
    logic cnt_last;
    logic free_stop;
    logic out_busy;
  } flags_t;

  function automatic logic [UPC_W-1:0] dispatch(input logic [FUNC_W-1:0] func);
    logic [UPC_W-1:0] t;
    unique case (func)
      FUNC_READ:   t = UPC_RD0;
      FUNC_WRITE:  t = UPC_WR0;
      FUNC_ALLOC:  t = UPC_AL0;
      FUNC_EXTEND: t = UPC_EX0;
      FUNC_FREE:   t = UPC_WK0;
      default:     t = UPC_DONE;
    endcase
    return t;
  endfunction

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    w = '0;
    unique case (upc)
      // clearing pass, one entry a step
      UPC_CLR: begin
        w.wr_en = 1'b1; w.wr_addr = ADDR_SCAN; w.wr_data = DAT_FREE;
        w.scan_inc = 1'b1;
        w.cond = C_CLR_LAST; w.cond_neg = 1'b1; w.target = UPC_CLR;
      end
      UPC_IDLE: begin
        w.ld_cmd = 1'b1;
        w.cond = C_ACCEPT; w.cond_neg = 1'b1; w.target = UPC_IDLE;
      end
      UPC_DISPATCH: begin
        w.cond = C_DISPATCH;
      end
      UPC_RD0: begin
        w.rd_en = 1'b1; w.rd_addr = ADDR_CUR;
        w.cond = C_OUT_RANGE; w.target = UPC_DONE;
      end
      UPC_RD1: begin
        w.set_eout = 1'b1;
        w.cond = C_ALWAYS; w.target = UPC_DONE;
      end
      UPC_WR0: begin
        w.cond = C_OUT_RANGE; w.target = UPC_DONE;
      end
      UPC_WR1: begin
        w.wr_en = 1'b1; w.wr_addr = ADDR_CUR; w.wr_data = DAT_VALUE;
        w.cond = C_ALWAYS; w.target = UPC_DONE;
      end
      UPC_AL0: begin
        w.rd_en = 1'b1; w.rd_addr = ADDR_SCAN;
        w.cond = C_SCAN_END; w.target = UPC_FULL;
      end
      UPC_AL1: begin
        w.scan_miss_inc = 1'b1;
        w.cond = C_FREE_HIT; w.cond_neg = 1'b1; w.target = UPC_AL0;
      end
      UPC_AL_OK: begin
        w.wr_en = 1'b1; w.wr_addr = ADDR_SCAN; w.wr_data = DAT_END;
        w.set_cout = 1'b1;
        w.cond = C_ALWAYS; w.target = UPC_DONE;
      end
      UPC_FULL: begin
        w.st_full = 1'b1;
        w.cond = C_ALWAYS; w.target = UPC_DONE;
      end
      UPC_EX0: begin
        w.cond = C_CNT_ZERO; w.target = UPC_DONE;
      end
      // chain walk shared by extend and free
      UPC_WK0: begin
        w.rd_en = 1'b1; w.rd_addr = ADDR_CUR;
        w.visit_inc = 1'b1;
        w.cond = C_WALK_BAD; w.target = UPC_BAD;
      end
      UPC_WK1: begin
        w.cond = C_RD_BAD; w.target = UPC_BAD;
      end
      UPC_WK2: begin
        w.tail_from_cur = 1'b1; w.cur_from_rdata = 1'b1;
        w.cond = C_RD_END; w.cond_neg = 1'b1; w.target = UPC_WK0;
      end
      UPC_WK3: begin
        w.cur_from_cmd = 1'b1;
        w.cond = C_IS_FREE; w.target = UPC_FR0;
      end
      UPC_ES0: begin
        w.rd_en = 1'b1; w.rd_addr = ADDR_SCAN;
        w.cond = C_SCAN_END; w.target = UPC_FULL;
      end
      UPC_ES1: begin
        w.scan_miss_inc = 1'b1;
        w.cond = C_FREE_HIT; w.cond_neg = 1'b1; w.target = UPC_ES0;
      end
      UPC_ES2: begin
        w.wr_en = 1'b1; w.wr_addr = ADDR_TAIL; w.wr_data = DAT_SCAN;
      end
      UPC_ES3: begin
        w.wr_en = 1'b1; w.wr_addr = ADDR_SCAN; w.wr_data = DAT_END;
        w.tail_from_scan = 1'b1; w.cnt_inc = 1'b1; w.scan_inc = 1'b1;
        w.cond = C_CNT_LAST; w.cond_neg = 1'b1; w.target = UPC_ES0;
      end
      UPC_ES_JMP: begin
        w.cond = C_ALWAYS; w.target = UPC_DONE;
      end
      UPC_BAD: begin
        w.st_broken = 1'b1;
        w.cond = C_ALWAYS; w.target = UPC_DONE;
      end
      UPC_FR0: begin
        w.rd_en = 1'b1; w.rd_addr = ADDR_CUR;
      end
      UPC_FR1: begin
        w.wr_en = 1'b1; w.wr_addr = ADDR_CUR; w.wr_data = DAT_FREE;
        w.cur_from_rdata = 1'b1;
        w.cond = C_FREE_STOP; w.cond_neg = 1'b1; w.target = UPC_FR0;
      end
      UPC_DONE: begin
        w.cond = C_OUT_BUSY; w.target = UPC_DONE;
      end
      UPC_PUSH: begin
        w.push = 1'b1;
        w.cond = C_ALWAYS; w.target = UPC_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/fatcm_datapath.sv =====
// table memory, working registers and result register of the chain manager
module fatcm_datapath #(
  parameter int TABLE_DEPTH = fatcm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fatcm_pkg::ucode_t           ctrl_i,
  input  logic                        accept_i,
  input  fatcm_pkg::in_item_t         in_data_i,
  input  logic                        cfg_valid_i,
  input  logic [fatcm_pkg::EIU_W-1:0] cfg_data_i,
  output fatcm_pkg::flags_t           flags_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fatcm_pkg::out_item_t        out_data_o
);
  import fatcm_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = AW + 1;

  logic [ENT_W-1:0] mem_q [TABLE_DEPTH];

  in_item_t          cmd_q;
  logic [ENT_W-1:0]  cur_q;
  logic [AW-1:0]     tail_q;
  logic [SW-1:0]     scan_q;
  logic [EIU_W-1:0]  visit_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [STAT_W-1:0] st_q;
  logic [CLU_W-1:0]  cout_q;
  logic [ENT_W-1:0]  eout_q;
  logic [ENT_W-1:0]  rdata_q;
  logic [EIU_W-1:0]  eiu_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [ENT_W-1:0]  wdata;
  logic [31:0]       lim;
  logic [31:0]       depth;
  logic              ld;
  logic              scan_step;

  assign depth = 32'(TABLE_DEPTH);
  assign ld    = ctrl_i.ld_cmd && accept_i;
  // free search stops at the smaller of the register and the depth
  assign lim   = (32'(eiu_q) < depth) ? 32'(eiu_q) : depth;
  assign scan_step = ctrl_i.scan_inc || (ctrl_i.scan_miss_inc && (rdata_q != ENT_FREE));

  always_comb begin
    unique case (ctrl_i.rd_addr)
      ADDR_SCAN: raddr = scan_q[AW-1:0];
      ADDR_TAIL: raddr = tail_q;
      default:   raddr = AW'(cur_q);
    endcase
    unique case (ctrl_i.wr_addr)
      ADDR_SCAN: waddr = scan_q[AW-1:0];
      ADDR_TAIL: waddr = tail_q;
      default:   waddr = AW'(cur_q);
    endcase
    unique case (ctrl_i.wr_data)
      DAT_END:   wdata = ENT_END;
      DAT_FREE:  wdata = ENT_FREE;
      DAT_SCAN:  wdata = ENT_W'(scan_q);
      default:   wdata = cmd_q.entry_value;
    endcase
  end

  always_comb begin
    flags_o.func      = cmd_q.func;
    flags_o.clr_last  = (scan_q == SW'(TABLE_DEPTH - 1));
    flags_o.out_range = (32'(cmd_q.cluster) >= depth);
    flags_o.scan_end  = (32'(scan_q) >= lim);
    flags_o.free_hit  = (rdata_q == ENT_FREE);
    flags_o.walk_bad  = (32'(cur_q) >= depth) ||
                        (({1'b0, visit_q} + (EIU_W+1)'(1)) > {1'b0, eiu_q});
    flags_o.rd_bad    = (rdata_q == ENT_FREE) || (rdata_q == ENT_INVALID);
    flags_o.rd_end    = (rdata_q == ENT_END);
    flags_o.cnt_zero  = (cmd_q.count == '0);
    flags_o.is_free   = (cmd_q.func == FUNC_FREE);
    flags_o.cnt_last  = (({1'b0, cnt_q} + (CNT_W+1)'(1)) == {1'b0, cmd_q.count});
    flags_o.free_stop = (rdata_q == ENT_END) || (32'(rdata_q) >= depth);
    flags_o.out_busy  = out_valid_q;
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      eiu_q       <= EIU_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        eiu_q <= cfg_data_i;
      end
      if (ld) begin
        scan_q <= '0;
      end else if (scan_step) begin
        scan_q <= scan_q + SW'(1);
      end
      if (ctrl_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      cmd_q   <= in_data_i;
      cur_q   <= ENT_W'(in_data_i.cluster);
      visit_q <= '0;
      cnt_q   <= '0;
      st_q    <= STATUS_OK;
      cout_q  <= '0;
      eout_q  <= '0;
    end else begin
      if (ctrl_i.cur_from_cmd) begin
        cur_q <= ENT_W'(cmd_q.cluster);
      end else if (ctrl_i.cur_from_rdata) begin
        cur_q <= rdata_q;
      end
      if (ctrl_i.tail_from_cur) begin
        tail_q <= AW'(cur_q);
      end else if (ctrl_i.tail_from_scan) begin
        tail_q <= scan_q[AW-1:0];
      end
      if (ctrl_i.visit_inc) begin
        visit_q <= visit_q + EIU_W'(1);
      end
      if (ctrl_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (ctrl_i.st_full) begin
        st_q <= STATUS_FULL;
      end else if (ctrl_i.st_broken) begin
        st_q <= STATUS_BROKEN;
      end
      if (ctrl_i.set_cout) begin
        cout_q <= CLU_W'(scan_q);
      end
      if (ctrl_i.set_eout) begin
        eout_q <= rdata_q;
      end
    end
    if (ctrl_i.push) begin
      out_q.status      <= st_q;
      out_q.cluster_out <= cout_q;
      out_q.count_out   <= cnt_q;
      out_q.entry_out   <= eout_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/fat_cluster_chain_manager.sv =====
// top level: microprogram sequencer over the fat table datapath
// result time grows, for allocate, with each used entry skipped; for extend, with each link walked,
//   each used entry skipped and each cluster appended; for free, with each chain entry walked
//   and freed; full or broken ends early
// one item at a time, set by the microprogram sequencer: the next beat can be taken in the cycle
//   after a result is loaded; a result waits in an output register while the next item runs
// reset: clears control state, then a clearing pass zeroes every table entry with in_stall_o high
module fat_cluster_chain_manager #(
  parameter int TABLE_DEPTH = fatcm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // operation beats
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fatcm_pkg::in_item_t         in_data_i,
  // result beats
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fatcm_pkg::out_item_t        out_data_o,
  // entries_in_use register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fatcm_pkg::EIU_W-1:0] cfg_data_i
);
  import fatcm_pkg::*;

  logic [UPC_W-1:0] upc_q;
  logic [UPC_W-1:0] upc_d;
  ucode_t           uw;
  flags_t           flags;
  logic             accept;
  logic             hit;

  // only the idle step takes a new operation
  assign accept      = in_valid_i && (upc_q == UPC_IDLE);
  assign in_stall_o  = (upc_q != UPC_IDLE);
  // writes land at once; the source must send them only while no operation is in flight (not enforced here)
  assign cfg_ready_o = 1'b1;

  // fetch the control word and pick the next step
  always_comb begin
    uw = ucode_rom(upc_q);
    unique case (uw.cond)
      C_ALWAYS:    hit = 1'b1;
      C_ACCEPT:    hit = accept;
      C_CLR_LAST:  hit = flags.clr_last;
      C_OUT_RANGE: hit = flags.out_range;
      C_SCAN_END:  hit = flags.scan_end;
      C_FREE_HIT:  hit = flags.free_hit;
      C_WALK_BAD:  hit = flags.walk_bad;
      C_RD_BAD:    hit = flags.rd_bad;
      C_RD_END:    hit = flags.rd_end;
      C_CNT_ZERO:  hit = flags.cnt_zero;
      C_IS_FREE:   hit = flags.is_free;
      C_CNT_LAST:  hit = flags.cnt_last;
      C_FREE_STOP: hit = flags.free_stop;
      C_OUT_BUSY:  hit = flags.out_busy;
      default:     hit = 1'b0;
    endcase
    // multiway jump on the latched operation code
    if (uw.cond == C_DISPATCH) begin
      upc_d = dispatch(flags.func);
    end else if (hit ^ uw.cond_neg) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  fatcm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (uw),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .flags_o     (flags),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/fatcm_checker.sv =====
// port-level checks of the chain manager and their bind
module fatcm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input fatcm_pkg::out_item_t out_data_o
);
  import fatcm_pkg::*;

  // one operation at a time: an accepted beat closes the input side
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accepted beat");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // failures carry no cluster or entry
  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |->
      (out_data_o.cluster_out == '0) && (out_data_o.entry_out == '0))
    else $error("failed result carries cluster or entry");

  // an entry comes back only from a plain read
  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.entry_out != '0) |->
      (out_data_o.cluster_out == '0) && (out_data_o.count_out == '0) &&
      (out_data_o.status == STATUS_OK))
    else $error("read result mixed with other fields");

endmodule

bind fat_cluster_chain_manager fatcm_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
